### rtl/mrr_pkg.sv
// Shared types, codes and the CRC-16/MODBUS byte step of the register reader.
package mrr_pkg;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_RX    = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TIMEOUT   = 3'd1,
    ST_CRC_ERR   = 3'd2,
    ST_EXCEPTION = 3'd3,
    ST_BAD_COUNT = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    CFG_SERVER_ADDR  = 3'd0,
    CFG_REG_ADDRESS  = 3'd1,
    CFG_SIGNED_MODE  = 3'd2,
    CFG_VALUE_OFFSET = 3'd3,
    CFG_SCALE_FACTOR = 3'd4,
    CFG_TIMEOUT      = 3'd5
  } cfg_index_e;

  localparam logic        KIND_TX       = 1'b0;
  localparam logic        KIND_DONE     = 1'b1;
  localparam logic [7:0]  FUNC_READ_HOLD = 8'h03;
  localparam logic [7:0]  EXCEPTION_BIT = 8'h80;
  localparam logic [7:0]  DATA_COUNT    = 8'h02;
  localparam logic [15:0] REG_COUNT     = 16'h0001;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;

  // One byte through the reflected CRC-16/MODBUS polynomial.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

### rtl/modbus_rtu_single_register_reader.sv
// Top level of the Modbus RTU master that reads one holding register.
//
//   channel | direction | handshake               | word
//   --------+-----------+-------------------------+---------------------------------------
//   in      | input     | in_valid_i / in_stall_o | cmd_i, rx_byte_i
//   out     | output    | out_valid_o/out_stall_i | kind_o, tx_byte_o, last_o, status_o,
//           |           |                         | exception_code_o, raw_value_o,
//           |           |                         | scaled_value_o
//   cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// An input word is held in an input register and processed from there straight into the
// output register, so one word per cycle is sustained when each word yields at most one
// result and the output is not stalled. A start yields eight transmit words, one per cycle
// from the frame generator unless the output stalls, and holds the processing stage until
// all are out. Reset leaves the reader idle with the configuration at its defaults. A stall
// on the output holds the output register and backs up into in_stall_o in the same cycle.
module modbus_rtu_single_register_reader
  import mrr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  rx_byte_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [7:0]  tx_byte_o,
  output logic        last_o,
  output logic [2:0]  status_o,
  output logic [7:0]  exception_code_o,
  output logic [15:0] raw_value_o,
  output logic signed [40:0] scaled_value_o,

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);

  // Configuration registers. Writes are always taken.
  logic [7:0]         server_addr_q;
  logic [15:0]        register_address_q;
  logic               signed_mode_q;
  logic signed [15:0] value_offset_q;
  logic signed [23:0] scale_factor_q;
  logic [15:0]        timeout_ticks_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      server_addr_q      <= 8'd1;
      register_address_q <= 16'd0;
      signed_mode_q      <= 1'b0;
      value_offset_q     <= 16'sd0;
      scale_factor_q     <= 24'sd65536;
      timeout_ticks_q    <= 16'd100;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SERVER_ADDR:  server_addr_q      <= cfg_data_i[7:0];
        CFG_REG_ADDRESS:  register_address_q <= cfg_data_i[15:0];
        CFG_SIGNED_MODE:  signed_mode_q      <= cfg_data_i[0];
        CFG_VALUE_OFFSET: value_offset_q     <= signed'(cfg_data_i[15:0]);
        CFG_SCALE_FACTOR: scale_factor_q     <= signed'(cfg_data_i);
        CFG_TIMEOUT:      timeout_ticks_q    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Input register.
  logic       s1_valid_q;
  logic [1:0] s1_cmd_q;
  logic [7:0] s1_byte_q;

  // Read state.
  logic        busy_q, busy_d;
  logic [2:0]  bytes_received_q, bytes_received_d;
  logic [15:0] running_crc_q, running_crc_d;
  logic [15:0] elapsed_ticks_q, elapsed_ticks_d;
  logic [7:0]  resp_func_q, resp_func_d;
  logic [7:0]  resp_count_q, resp_count_d;
  logic [7:0]  resp_hi_q, resp_hi_d;
  logic [7:0]  resp_lo_q, resp_lo_d;

  // Request frame sequencing: after the first byte, the remaining seven follow.
  logic       tx_active_q, tx_active_d;
  logic [2:0] tx_idx_q, tx_idx_d;

  // Output register.
  logic        out_valid_q, out_valid_d;
  logic        kind_q, kind_d;
  logic [7:0]  tx_byte_q, tx_byte_d;
  logic        last_q, last_d;
  logic [2:0]  status_q, status_d;
  logic [7:0]  exc_q, exc_d;
  logic [15:0] raw_q, raw_d;
  logic signed [40:0] scaled_q, scaled_d;

  logic [2:0]  frame_idx;
  logic [7:0]  frame_byte;
  logic        frame_last;

  mrr_frame_gen u_frame_gen (
    .server_addr_i      (server_addr_q),
    .register_address_i (register_address_q),
    .idx_i              (frame_idx),
    .byte_o             (frame_byte),
    .last_o             (frame_last)
  );

  assign frame_idx = tx_active_q ? tx_idx_q : 3'd0;

  logic        out_free;
  logic        produce;
  logic        adv;
  logic        s1_free;
  logic [15:0] ticks_inc;
  logic [15:0] crc_final;
  logic [15:0] raw_word;
  logic signed [17:0] base;
  logic signed [17:0] sum;
  logic signed [41:0] product;

  assign out_free = !out_valid_q || !out_stall_i;
  assign ticks_inc = elapsed_ticks_q + 16'd1;
  assign crc_final = running_crc_q ^ {s1_byte_q, 8'h00};
  assign raw_word  = {resp_hi_q, resp_lo_q};
  assign base      = signed_mode_q ? signed'({{2{raw_word[15]}}, raw_word})
                                   : signed'({2'b00, raw_word});
  assign sum       = base + 18'(value_offset_q);
  assign product   = sum * scale_factor_q;

  // Decide whether the held word yields a result, and the next read state.
  always_comb begin
    produce          = 1'b0;
    busy_d           = busy_q;
    bytes_received_d = bytes_received_q;
    running_crc_d    = running_crc_q;
    elapsed_ticks_d  = elapsed_ticks_q;
    resp_func_d      = resp_func_q;
    resp_count_d     = resp_count_q;
    resp_hi_d        = resp_hi_q;
    resp_lo_d        = resp_lo_q;
    kind_d           = KIND_DONE;
    tx_byte_d        = 8'h00;
    last_d           = 1'b0;
    status_d         = ST_OK;
    exc_d            = 8'h00;
    raw_d            = 16'h0000;
    scaled_d         = '0;

    case (s1_cmd_q)
      CMD_START: begin
        // Restart from scratch and send the first request byte.
        produce          = 1'b1;
        busy_d           = 1'b1;
        bytes_received_d = 3'd0;
        running_crc_d    = CRC_INIT;
        elapsed_ticks_d  = 16'd0;
        kind_d           = KIND_TX;
        tx_byte_d        = frame_byte;
        last_d           = frame_last;
      end
      CMD_TICK: begin
        if (busy_q) begin
          elapsed_ticks_d = ticks_inc;
          if (ticks_inc >= timeout_ticks_q) begin
            busy_d   = 1'b0;
            produce  = 1'b1;
            status_d = ST_TIMEOUT;
          end
        end
      end
      CMD_RX: begin
        if (busy_q) begin
          bytes_received_d = bytes_received_q + 3'd1;
          case (bytes_received_q)
            3'd0, 3'd1, 3'd2, 3'd3, 3'd4: begin
              running_crc_d = crc_byte(running_crc_q, s1_byte_q);
              case (bytes_received_q)
                3'd1:    resp_func_d  = s1_byte_q;
                3'd2:    resp_count_d = s1_byte_q;
                3'd3:    resp_hi_d    = s1_byte_q;
                3'd4:    resp_lo_d    = s1_byte_q;
                default: ;
              endcase
            end
            3'd5: begin
              running_crc_d = running_crc_q ^ {8'h00, s1_byte_q};
            end
            default: begin
              // Seventh byte: check CRC, then exception bit, then byte count.
              running_crc_d    = crc_final;
              bytes_received_d = 3'd7;
              busy_d           = 1'b0;
              produce          = 1'b1;
              if (crc_final != 16'h0000) begin
                status_d = ST_CRC_ERR;
              end else if ((resp_func_q & EXCEPTION_BIT) != 8'h00) begin
                status_d = ST_EXCEPTION;
                exc_d    = resp_count_q;
              end else if (resp_count_q != DATA_COUNT) begin
                status_d = ST_BAD_COUNT;
              end else begin
                status_d = ST_OK;
                raw_d    = raw_word;
                scaled_d = product[40:0];
              end
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  assign adv        = s1_valid_q && !tx_active_q && (!produce || out_free);
  assign s1_free    = !s1_valid_q || adv;
  assign in_stall_o = !s1_free;

  // Output register and frame sequencer control.
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    tx_active_d = tx_active_q;
    tx_idx_d    = tx_idx_q;
    if (tx_active_q) begin
      if (out_free) begin
        out_valid_d = 1'b1;
        tx_idx_d    = tx_idx_q + 3'd1;
        if (frame_last) begin
          tx_active_d = 1'b0;
        end
      end
    end else if (adv && produce) begin
      out_valid_d = 1'b1;
      if (s1_cmd_q == CMD_START) begin
        tx_active_d = 1'b1;
        tx_idx_d    = 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q       <= 1'b0;
      busy_q           <= 1'b0;
      bytes_received_q <= 3'd0;
      running_crc_q    <= CRC_INIT;
      elapsed_ticks_q  <= 16'd0;
      tx_active_q      <= 1'b0;
      tx_idx_q         <= 3'd0;
      out_valid_q      <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_q <= in_valid_i;
      end
      if (adv) begin
        busy_q           <= busy_d;
        bytes_received_q <= bytes_received_d;
        running_crc_q    <= running_crc_d;
        elapsed_ticks_q  <= elapsed_ticks_d;
      end
      tx_active_q <= tx_active_d;
      tx_idx_q    <= tx_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (s1_free && in_valid_i) begin
      s1_cmd_q  <= cmd_i;
      s1_byte_q <= rx_byte_i;
    end
    if (adv) begin
      resp_func_q  <= resp_func_d;
      resp_count_q <= resp_count_d;
      resp_hi_q    <= resp_hi_d;
      resp_lo_q    <= resp_lo_d;
    end
    if (tx_active_q && out_free) begin
      kind_q    <= KIND_TX;
      tx_byte_q <= frame_byte;
      last_q    <= frame_last;
      status_q  <= ST_OK;
      exc_q     <= 8'h00;
      raw_q     <= 16'h0000;
      scaled_q  <= '0;
    end else if (!tx_active_q && adv && produce) begin
      kind_q    <= kind_d;
      tx_byte_q <= tx_byte_d;
      last_q    <= last_d;
      status_q  <= status_d;
      exc_q     <= exc_d;
      raw_q     <= raw_d;
      scaled_q  <= scaled_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = kind_q;
  assign tx_byte_o        = tx_byte_q;
  assign last_o           = last_q;
  assign status_o         = status_q;
  assign exception_code_o = exc_q;
  assign raw_value_o      = raw_q;
  assign scaled_value_o   = scaled_q;

endmodule

### rtl/mrr_frame_gen.sv
// Request frame generator: gives the read request byte at a given position.
module mrr_frame_gen
  import mrr_pkg::*;
(
  input  logic [7:0]  server_addr_i,
  input  logic [15:0] register_address_i,
  input  logic [2:0]  idx_i,
  output logic [7:0]  byte_o,
  output logic        last_o
);

  logic [7:0]  frame [6];
  logic [15:0] crc;

  always_comb begin
    frame[0] = server_addr_i;
    frame[1] = FUNC_READ_HOLD;
    frame[2] = register_address_i[15:8];
    frame[3] = register_address_i[7:0];
    frame[4] = REG_COUNT[15:8];
    frame[5] = REG_COUNT[7:0];
    crc = CRC_INIT;
    for (int i = 0; i < 6; i++) begin
      crc = crc_byte(crc, frame[i]);
    end
  end

  always_comb begin
    case (idx_i)
      3'd6:    byte_o = crc[7:0];
      3'd7:    byte_o = crc[15:8];
      default: byte_o = frame[idx_i[2:0] < 3'd6 ? idx_i : 3'd0];
    endcase
  end

  assign last_o = (idx_i == 3'd7);

endmodule
